/* hw/rtl/ntpd_pkg.sv */
// Shared types, constants and tables of the note token parser.
package ntpd_pkg;

  localparam int unsigned SampleRateDefault = 44100;
  localparam logic [9:0]  TempoReset   = 10'd120;
  localparam logic [3:0]  OctaveReset  = 4'd4;
  localparam logic [23:0] BeatReset    = 24'h010000;
  localparam logic [24:0] FracRecip    = 25'd27487791;
  localparam logic [21:0] PitchMax     = 22'h3FFFFF;
  localparam logic [29:0] DurMax       = 30'h3FFFFFFF;
  localparam int unsigned DivSteps     = 32;

  typedef enum logic [2:0] {
    PH_LETTER = 3'd0,
    PH_MODS   = 3'd1,
    PH_BINT   = 3'd2,
    PH_BFRAC  = 3'd3,
    PH_IGNORE = 3'd4
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FDIV = 5'b00010,
    S_MUL  = 5'b00100,
    S_DDIV = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  typedef struct packed {
    logic take;
    logic capture;
    logic div_step;
    logic commit;
    logic mul;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic token_end;
    logic commit_req;
    logic div_last;
  } status_t;

  function automatic logic [13:0] freq_q8(input logic [3:0] ix);
    logic [13:0] f;
    begin
      case (ix)
        4'd0:    f = 14'd7903;
        4'd1:    f = 14'd8371;
        4'd2:    f = 14'd8870;
        4'd3:    f = 14'd9398;
        4'd4:    f = 14'd9956;
        4'd5:    f = 14'd10547;
        4'd6:    f = 14'd11174;
        4'd7:    f = 14'd11840;
        4'd8:    f = 14'd12544;
        4'd9:    f = 14'd13289;
        4'd10:   f = 14'd14080;
        4'd11:   f = 14'd14917;
        default: f = 14'd15805;
      endcase
      return f;
    end
  endfunction

  function automatic logic signed [5:0] letter_index(input logic [7:0] c);
    logic signed [5:0] v;
    begin
      case (c)
        "c":     v = 6'sd1;
        "d":     v = 6'sd3;
        "e":     v = 6'sd5;
        "f":     v = 6'sd6;
        "g":     v = 6'sd8;
        "a":     v = 6'sd10;
        "b":     v = 6'sd12;
        "r":     v = -6'sd1;
        default: v = 6'sd0;
      endcase
      return v;
    end
  endfunction

  function automatic logic [13:0] pow10_scale(input logic [13:0] fr, input logic [2:0] fd);
    logic [13:0] v;
    begin
      case (fd)
        3'd0:    v = 14'd0;
        3'd1:    v = 14'(fr * 14'd1000);
        3'd2:    v = 14'(fr * 14'd100);
        3'd3:    v = 14'(fr * 14'd10);
        default: v = fr;
      endcase
      return v;
    end
  endfunction

endpackage

/* hw/rtl/ntpd_if.sv */
// Channel interfaces: character input, result output and tempo write.
interface ntpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       token_end;
  modport source (output valid, output symbol, output token_end, input ready);
  modport sink (input valid, input symbol, input token_end, output ready);
endinterface

interface ntpd_out_if;
  logic        valid;
  logic        ready;
  logic        is_rest;
  logic [21:0] pitch_q8;
  logic [29:0] duration_samples;
  modport source (output valid, output is_rest, output pitch_q8, output duration_samples,
                  input ready);
  modport sink (input valid, input is_rest, input pitch_q8, input duration_samples,
                output ready);
endinterface

interface ntpd_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/ntpd_ctrl.sv */
// Controller state machine sequencing parse, beat commit, multiply, divide and output load.
module ntpd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ntpd_pkg::status_t status_i,
  output ntpd_pkg::cmd_t    cmd_o
);

  ntpd_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic out_free;

  assign in_ready_o  = (state_q == ntpd_pkg::S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ntpd_pkg::S_IDLE: begin
        cmd_o.take = accept;
        if (accept && status_i.token_end) begin
          cmd_o.capture = 1'b1;
          state_d = status_i.commit_req ? ntpd_pkg::S_FDIV : ntpd_pkg::S_MUL;
        end
      end
      ntpd_pkg::S_FDIV: begin
        cmd_o.commit = 1'b1;
        state_d = ntpd_pkg::S_MUL;
      end
      ntpd_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ntpd_pkg::S_DDIV;
      end
      ntpd_pkg::S_DDIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ntpd_pkg::S_DONE;
      end
      ntpd_pkg::S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ntpd_pkg::S_IDLE;
        end
      end
      default: state_d = ntpd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ntpd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hw/rtl/ntpd_dp.sv */
// Datapath: token parser, pitch lookup, serial tempo divider and result register.
module ntpd_dp #(
  parameter int unsigned SAMPLE_RATE_HZ = ntpd_pkg::SampleRateDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        symbol_i,
  input  logic              token_end_i,
  input  logic              cfg_valid_i,
  input  logic [9:0]        cfg_data_i,
  input  ntpd_pkg::cmd_t    cmd_i,
  output ntpd_pkg::status_t status_o,
  output logic              is_rest_o,
  output logic [21:0]       pitch_q8_o,
  output logic [29:0]       duration_samples_o
);

  localparam logic [23:0] SamplesPerMin = 24'(SAMPLE_RATE_HZ * 60);

  logic [9:0]        tempo_q;
  logic [3:0]        octave_q, octave_d;
  logic [23:0]       beat_q;
  ntpd_pkg::phase_e  phase_q, phase_d;
  logic signed [5:0] idx_q, idx_d;
  logic [7:0]        ip_q, ip_d;
  logic [13:0]       fr_q, fr_d;
  logic [2:0]        fd_q, fd_d;
  logic [7:0]        ip_hold_q;

  logic        digit;
  logic [3:0]  dval;
  logic [11:0] ip_ten;
  logic [17:0] fr_ten;

  logic [31:0] quo_q, quo_d;
  logic [9:0]  rem_q, rem_d;
  logic [9:0]  dvs_q;
  logic [4:0]  cnt_q;
  logic [10:0] rem_sh;
  logic        ge;

  logic        rest_q;
  logic [21:0] pitch_q;
  logic [21:0] pitch_w;
  logic        rest_w;
  logic [28:0] shifted;
  logic [3:0]  tix;
  logic [47:0] prod;
  logic [37:0] frac_prod;

  logic        out_rest_q;
  logic [21:0] out_pitch_q;
  logic [29:0] out_dur_q;

  assign digit  = (symbol_i >= "0") && (symbol_i <= "9");
  assign dval   = 4'(symbol_i - "0");
  assign ip_ten = 12'({4'd0, ip_q} * 12'd10) + 12'(dval);
  assign fr_ten = 18'({4'd0, fr_q} * 18'd10) + 18'(dval);

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    octave_d = octave_q;
    ip_d     = ip_q;
    fr_d     = fr_q;
    fd_d     = fd_q;
    case (phase_q)
      ntpd_pkg::PH_LETTER: begin
        idx_d   = ntpd_pkg::letter_index(symbol_i);
        phase_d = ntpd_pkg::PH_MODS;
      end
      ntpd_pkg::PH_MODS: begin
        if (symbol_i == "#") begin
          if (idx_q != 6'sd31) idx_d = idx_q + 6'sd1;
        end else if (symbol_i == "b") begin
          if (idx_q != -6'sd32) idx_d = idx_q - 6'sd1;
        end else if (digit) begin
          octave_d = dval;
        end else if (symbol_i == "/") begin
          ip_d    = '0;
          fr_d    = '0;
          fd_d    = '0;
          phase_d = ntpd_pkg::PH_BINT;
        end
      end
      ntpd_pkg::PH_BINT: begin
        if (digit) begin
          ip_d = (ip_ten > 12'd255) ? 8'd255 : ip_ten[7:0];
        end else if (symbol_i == ".") begin
          phase_d = ntpd_pkg::PH_BFRAC;
        end else begin
          phase_d = ntpd_pkg::PH_IGNORE;
        end
      end
      ntpd_pkg::PH_BFRAC: begin
        if (digit) begin
          if (fd_q < 3'd4) begin
            fr_d = fr_ten[13:0];
            fd_d = fd_q + 3'd1;
          end
        end else begin
          phase_d = ntpd_pkg::PH_IGNORE;
        end
      end
      default: ;
    endcase
  end

  // pitch of the finished token
  always_comb begin
    rest_w  = idx_d < 0;
    tix     = (idx_d > 6'sd12) ? 4'd12 : idx_d[3:0];
    shifted = 29'({15'd0, ntpd_pkg::freq_q8(tix)} << octave_d) >> 1;
    if (rest_w) pitch_w = '0;
    else if (shifted > 29'(ntpd_pkg::PitchMax)) pitch_w = ntpd_pkg::PitchMax;
    else pitch_w = shifted[21:0];
  end

  // beat fraction: frac4 * 65536 / 10000 by reciprocal multiply, exact for frac4 < 10000
  assign frac_prod = 38'(quo_q[13:0]) * 38'(ntpd_pkg::FracRecip);
  assign prod      = 48'(SamplesPerMin) * 48'(beat_q);

  assign rem_sh = {rem_q, quo_q[31]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_d  = ge ? 10'(rem_sh - {1'b0, dvs_q}) : rem_sh[9:0];
  assign quo_d  = {quo_q[30:0], ge};

  assign status_o.token_end  = token_end_i;
  assign status_o.commit_req = (phase_d == ntpd_pkg::PH_BINT) ||
                               (phase_d == ntpd_pkg::PH_BFRAC) ||
                               (phase_d == ntpd_pkg::PH_IGNORE);
  assign status_o.div_last   = (cnt_q == 5'(ntpd_pkg::DivSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q  <= ntpd_pkg::TempoReset;
      octave_q <= ntpd_pkg::OctaveReset;
      beat_q   <= ntpd_pkg::BeatReset;
      phase_q  <= ntpd_pkg::PH_LETTER;
      idx_q    <= '0;
      ip_q     <= '0;
      fr_q     <= '0;
      fd_q     <= '0;
    end else begin
      if (cfg_valid_i) tempo_q <= cfg_data_i;
      if (cmd_i.take) begin
        octave_q <= octave_d;
        if (cmd_i.capture) begin
          phase_q <= ntpd_pkg::PH_LETTER;
          idx_q   <= '0;
          ip_q    <= '0;
          fr_q    <= '0;
          fd_q    <= '0;
        end else begin
          phase_q <= phase_d;
          idx_q   <= idx_d;
          ip_q    <= ip_d;
          fr_q    <= fr_d;
          fd_q    <= fd_d;
        end
      end
      if (cmd_i.commit) beat_q <= {ip_hold_q, frac_prod[37:22]};
    end
  end

  // payload and divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rest_q    <= rest_w;
      pitch_q   <= pitch_w;
      ip_hold_q <= ip_d;
      quo_q     <= {18'd0, ntpd_pkg::pow10_scale(fr_d, fd_d)};
      rem_q     <= '0;
      cnt_q     <= '0;
    end else if (cmd_i.mul) begin
      quo_q <= prod[47:16];
      rem_q <= '0;
      dvs_q <= (tempo_q == 10'd0) ? 10'd1 : tempo_q;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q + 5'd1;
    end
    if (cmd_i.load_out) begin
      out_rest_q  <= rest_q;
      out_pitch_q <= pitch_q;
      out_dur_q   <= (quo_q > 32'(ntpd_pkg::DurMax)) ? ntpd_pkg::DurMax : quo_q[29:0];
    end
  end

  assign is_rest_o          = out_rest_q;
  assign pitch_q8_o         = out_pitch_q;
  assign duration_samples_o = out_dur_q;

endmodule

/* hw/rtl/note_token_to_pitch_duration.sv */
// Top level of the note token parser: turns characters into pitch and duration words.
//
// in_ch takes one ASCII character per word; token_end marks the last one of a token.
// Each token yields one word on out_ch: is_rest, pitch_q8 (Hz, Q8) and
// duration_samples = SAMPLE_RATE_HZ*60*beat/tempo, truncated.
// cfg_ch writes tempo_bpm and is always ready; the user must write it only while
// the block is idle, which the block itself does not enforce. A character that does
// not end a token leaves in_ch ready for the next character. A token end runs the
// duration multiply, a 32-step tempo divide and the output load; when the token
// carries a beat after '/', a constant multiply first converts the beat fraction.
// in_ch stays not ready from a token end until its result sits in the output
// register; the output register holds a finished word while out_ch stalls, and a
// next result waits in the controller until the word is taken.
// Reset sets tempo 120, octave 4, beat 1.0 and starts a fresh token.
module note_token_to_pitch_duration #(
  parameter int unsigned SAMPLE_RATE_HZ = ntpd_pkg::SampleRateDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ntpd_in_if.sink    in_ch,
  ntpd_out_if.source out_ch,
  ntpd_cfg_if.sink   cfg_ch
);

  ntpd_pkg::cmd_t    cmd;
  ntpd_pkg::status_t status;

  assign cfg_ch.ready = 1'b1;

  ntpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ntpd_dp #(
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .symbol_i           (in_ch.symbol),
    .token_end_i        (in_ch.token_end),
    .cfg_valid_i        (cfg_ch.valid),
    .cfg_data_i         (cfg_ch.data),
    .cmd_i              (cmd),
    .status_o           (status),
    .is_rest_o          (out_ch.is_rest),
    .pitch_q8_o         (out_ch.pitch_q8),
    .duration_samples_o (out_ch.duration_samples)
  );

  a_busy_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready && in_ch.token_end |=> !in_ch.ready)
    else $error("input ready right after a token end");

  a_rest_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.is_rest |-> out_ch.pitch_q8 == 22'd0)
    else $error("rest with nonzero pitch");

  a_note_sounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.is_rest |-> out_ch.pitch_q8 != 22'd0)
    else $error("note with zero pitch");

endmodule
